FILE: rtl/i2cmbe_pkg.sv
// Package for the I2C master bit engine: command and phase payload types,
// opcode enum and shared constants. No dependencies.
package i2cmbe_pkg;

  localparam int unsigned TICK_W      = 16;
  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd100;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_ACK      = 3'd2,
    OP_NACK     = 3'd3,
    OP_TEST_ACK = 3'd4,
    OP_WRITE    = 3'd5,
    OP_READ     = 3'd6
  } op_e;

  localparam logic [2:0] OPCODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic [7:0] bus_levels;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       last_phase;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } phase_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] tx_byte;
    logic [7:0] bus_levels;
  } cmd_entry_t;

endpackage

FILE: rtl/i2cmbe_if.sv
// Handshake channel interfaces: command in, phase out, tick-count config.
// Depends on i2cmbe_pkg.
interface i2cmbe_cmd_if;
  logic               valid;
  logic               ready;
  i2cmbe_pkg::cmd_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cmbe_phase_if;
  logic               valid;
  logic               ready;
  i2cmbe_pkg::phase_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cmbe_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [i2cmbe_pkg::TICK_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/i2cmbe_cmd_front.sv
// Command front end: accepts command beats, drops the unused opcode and
// registers the decoded entry for the queue. Depends on i2cmbe_pkg, i2cmbe_if.
module i2cmbe_cmd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  i2cmbe_cmd_if.sink             cmd_i,
  output i2cmbe_pkg::cmd_entry_t ent_o,
  output logic                   ent_valid_o,
  input  logic                   ent_ready_i
);
  import i2cmbe_pkg::*;

  logic       valid_q;
  cmd_entry_t ent_q;
  logic       accept;

  assign cmd_i.ready = !valid_q || ent_ready_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      valid_q <= cmd_i.valid && (cmd_i.data.opcode != OPCODE_UNUSED);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q.op         <= op_e'(cmd_i.data.opcode);
      ent_q.tx_byte    <= cmd_i.data.tx_byte;
      ent_q.bus_levels <= cmd_i.data.bus_levels;
    end
  end

  assign ent_o       = ent_q;
  assign ent_valid_o = valid_q;

endmodule

FILE: rtl/i2cmbe_cmd_fifo.sv
// Small command queue between the front end and the phase sequencer.
// Depends on i2cmbe_pkg.
module i2cmbe_cmd_fifo #(
  parameter int unsigned Depth = i2cmbe_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2cmbe_pkg::cmd_entry_t push_data_i,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  output i2cmbe_pkg::cmd_entry_t pop_data_o,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i
);
  import i2cmbe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/i2cmbe_phase_seq.sv
// Phase sequencer: walks one command through its SCL/SDA phases, holds each
// phase for the configured tick count. Depends on i2cmbe_pkg, i2cmbe_if.
module i2cmbe_phase_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2cmbe_pkg::cmd_entry_t ent_i,
  input  logic                   ent_valid_i,
  output logic                   ent_ready_o,
  i2cmbe_cfg_if.sink             cfg_i,
  i2cmbe_phase_if.source         phase_o
);
  import i2cmbe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GEN,
    S_EMIT,
    S_HOLD
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic [4:0]        idx_q;
  logic [7:0]        shift_q;
  logic [7:0]        lev_q;
  logic [7:0]        rx_q;
  logic              line_scl_q, line_sda_q;
  logic [TICK_W-1:0] timer_q;
  logic [TICK_W-1:0] ticks_q;
  phase_t            out_q;
  logic              out_valid_q;

  phase_t            ph;
  logic [4:0]        last_idx;
  logic              is_last;

  always_comb begin
    case (op_q)
      OP_NACK:           last_idx = 5'd1;
      OP_WRITE, OP_READ: last_idx = 5'd16;
      default:           last_idx = 5'd2;
    endcase
  end

  assign is_last = (idx_q == last_idx);

  always_comb begin
    ph            = '0;
    ph.last_phase = is_last;
    case (op_q)
      OP_START: begin
        ph.scl_level = (idx_q != 5'd2);
        ph.sda_drive = (idx_q == 5'd0);
      end
      OP_STOP: begin
        ph.scl_level = (idx_q != 5'd0);
        ph.sda_drive = (idx_q == 5'd2);
      end
      OP_ACK: begin
        ph.scl_level = (idx_q == 5'd0);
        ph.sda_drive = (idx_q == 5'd2);
      end
      OP_NACK: begin
        ph.scl_level = (idx_q == 5'd0);
        ph.sda_drive = 1'b1;
      end
      OP_TEST_ACK: begin
        ph.scl_level   = (idx_q == 5'd0) ? line_scl_q : (idx_q == 5'd1);
        ph.sda_drive   = 1'b1;
        ph.ack_missing = is_last && lev_q[0];
      end
      OP_WRITE: begin
        if (is_last) begin
          ph.scl_level = 1'b0;
          ph.sda_drive = line_sda_q;
        end else begin
          ph.scl_level = idx_q[0] || ((idx_q == 5'd0) && line_scl_q);
          ph.sda_drive = shift_q[7];
        end
      end
      OP_READ: begin
        ph.scl_level = (idx_q == 5'd0) ? line_scl_q : idx_q[0];
        ph.sda_drive = 1'b1;
        ph.rx_byte   = is_last ? rx_q : 8'h00;
      end
      default: begin
        ph.scl_level = line_scl_q;
        ph.sda_drive = line_sda_q;
      end
    endcase
  end

  assign ent_ready_o   = (state_q == S_IDLE);
  assign phase_o.valid = out_valid_q;
  assign phase_o.data  = out_q;
  assign cfg_i.ready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
    end else if (cfg_i.valid) begin
      ticks_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_START;
      idx_q       <= '0;
      shift_q     <= '0;
      lev_q       <= '0;
      rx_q        <= '0;
      line_scl_q  <= 1'b1;
      line_sda_q  <= 1'b1;
      timer_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (ent_valid_i) begin
            op_q    <= ent_i.op;
            shift_q <= ent_i.tx_byte;
            lev_q   <= ent_i.bus_levels;
            rx_q    <= '0;
            idx_q   <= '0;
            state_q <= S_GEN;
          end
        end
        S_GEN: begin
          out_q       <= ph;
          out_valid_q <= 1'b1;
          line_scl_q  <= ph.scl_level;
          line_sda_q  <= ph.sda_drive;
          if (idx_q[0] && (op_q == OP_WRITE)) begin
            shift_q <= {shift_q[6:0], 1'b0};
          end
          if (idx_q[0] && (op_q == OP_READ)) begin
            rx_q  <= {rx_q[6:0], lev_q[7]};
            lev_q <= {lev_q[6:0], 1'b0};
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (phase_o.ready) begin
            out_valid_q <= 1'b0;
            timer_q     <= (ticks_q == '0) ? '0 : ticks_q - TICK_W'(1);
            state_q     <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (timer_q == '0) begin
            if (out_q.last_phase) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 5'd1;
              state_q <= S_GEN;
            end
          end else begin
            timer_q <= timer_q - TICK_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ack_flag_only_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_o.valid && phase_o.data.ack_missing |->
      (op_q == OP_TEST_ACK) && phase_o.data.last_phase)
    else $error("ack_missing outside test ack last beat");

  a_rx_only_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_o.valid && (phase_o.data.rx_byte != 8'h00) |->
      (op_q == OP_READ) && phase_o.data.last_phase)
    else $error("rx_byte set outside read last beat");

  a_lines_stable_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOLD |=> $stable(line_scl_q) && $stable(line_sda_q))
    else $error("line levels moved during hold");

  a_no_pop_with_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_ready_o |-> !phase_o.valid)
    else $error("command popped while a phase beat is pending");

endmodule

FILE: rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: front end, command queue, phase
// sequencer. Depends on i2cmbe_pkg, i2cmbe_if and the three submodules.
//
//   port     dir   role
//   cmd_i    in    command beat: opcode, tx_byte, bus_levels
//   cfg_i    in    phase_ticks write (always ready)
//   phase_o  out   line phase beat: scl, sda, last, rx_byte, ack_missing
//
// Each phase is built, presented and then held for phase_ticks by the hold timer
// in the sequencer; a command runs through its N phases (2..17) one after another.
// Commands queue ahead through the front register and the command queue while
// the sequencer works. A stalled phase beat holds the sequencer; the hold
// starts once the beat is taken. Reset leaves both lines released and
// phase_ticks at 100.
module i2c_master_bit_engine #(
  parameter int unsigned CmdQueueDepth = i2cmbe_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  i2cmbe_cmd_if.sink     cmd_i,
  i2cmbe_cfg_if.sink     cfg_i,
  i2cmbe_phase_if.source phase_o
);
  import i2cmbe_pkg::*;

  cmd_entry_t front_ent, queue_ent;
  logic       front_valid, front_ready;
  logic       queue_valid, queue_ready;

  i2cmbe_cmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .ent_o       (front_ent),
    .ent_valid_o (front_valid),
    .ent_ready_i (front_ready)
  );

  i2cmbe_cmd_fifo #(
    .Depth (CmdQueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_ent),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_ent),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  i2cmbe_phase_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (queue_ent),
    .ent_valid_i (queue_valid),
    .ent_ready_o (queue_ready),
    .cfg_i       (cfg_i),
    .phase_o     (phase_o)
  );

endmodule
